>>> src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// shared types and constants for the pad stick and trigger clamp
// ----------------------------------------------------------------------------
package psc_pkg;

  // field widths
  localparam int AXIS_W = 8;
  localparam int LIM_W  = 7;
  localparam int TRIG_W = 8;
  localparam int RAD_W  = 7;

  // divider operand widths (numerator below 128 times divisor)
  localparam int NUM_W = 21;
  localparam int DEN_W = 15;
  localparam int QUO_W = 7;

  // pipeline depths
  localparam int SQRT_STAGES = 4;
  localparam int DIV_STAGES  = 4;
  localparam int STICK_LAT   = 3 + SQRT_STAGES + DIV_STAGES;

  // default radii
  localparam int MAIN_RADIUS_DEF = 56;
  localparam int SUB_RADIUS_DEF  = 44;

  // register reset values
  localparam logic [TRIG_W-1:0] TRIG_MIN_RST = 8'd30;
  localparam logic [TRIG_W-1:0] TRIG_MAX_RST = 8'd180;
  localparam logic [LIM_W-1:0]  MAIN_DEAD_RST = 7'd15;
  localparam logic [LIM_W-1:0]  MAIN_MAX_RST  = 7'd72;
  localparam logic [LIM_W-1:0]  MAIN_XY_RST   = 7'd40;
  localparam logic [LIM_W-1:0]  SUB_DEAD_RST  = 7'd15;
  localparam logic [LIM_W-1:0]  SUB_MAX_RST   = 7'd59;
  localparam logic [LIM_W-1:0]  SUB_XY_RST    = 7'd31;

  // register map index
  typedef enum logic [2:0] {
    REG_TRIG_MIN  = 3'd0,
    REG_TRIG_MAX  = 3'd1,
    REG_MAIN_DEAD = 3'd2,
    REG_MAIN_MAX  = 3'd3,
    REG_MAIN_XY   = 3'd4,
    REG_SUB_DEAD  = 3'd5,
    REG_SUB_MAX   = 3'd6,
    REG_SUB_XY    = 3'd7
  } reg_idx_t;

  // per stick limits
  typedef struct packed {
    logic [LIM_W-1:0] dead;
    logic [LIM_W-1:0] max;
    logic [LIM_W-1:0] xy;
  } stk_cfg_t;

endpackage

>>> src/psc_isqrt.sv
// ----------------------------------------------------------------------------
// psc_isqrt
// pipelined integer square root, two result bits per stage
// ----------------------------------------------------------------------------
module psc_isqrt
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] val,
  output logic [7:0]  root
);

  typedef struct packed {
    logic [15:0] v;
    logic [11:0] rem;
    logic [7:0]  root;
  } sq_t;

  sq_t st_r   [SQRT_STAGES];
  sq_t st_nxt [SQRT_STAGES];

  // two restoring steps per stage
  always_comb begin
    sq_t         cur;
    logic [11:0] tmp;
    logic [11:0] trial;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      if (s == 0) begin
        cur = '{v: val, rem: '0, root: '0};
      end else begin
        cur = st_r[s-1];
      end
      for (int j = 0; j < 2; j++) begin
        tmp   = {cur.rem[9:0], cur.v[15:14]};
        trial = {2'b00, cur.root, 2'b01};
        if (tmp >= trial) begin
          cur.rem  = tmp - trial;
          cur.root = {cur.root[6:0], 1'b1};
        end else begin
          cur.rem  = tmp;
          cur.root = {cur.root[6:0], 1'b0};
        end
        cur.v = {cur.v[13:0], 2'b00};
      end
      st_nxt[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign root = st_r[SQRT_STAGES-1].root;

endmodule

>>> src/psc_div.sv
// ----------------------------------------------------------------------------
// psc_div
// pipelined restoring divider, quotient known to stay below 128
// ----------------------------------------------------------------------------
module psc_div
  import psc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] d;
    logic [QUO_W-1:0] q;
  } dv_t;

  dv_t st_r   [DIV_STAGES];
  dv_t st_nxt [DIV_STAGES];

  // two quotient bits per stage, msb first
  always_comb begin
    dv_t            cur;
    logic [NUM_W:0] sh;
    int             k;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        cur = '{rem: num, d: den, q: '0};
      end else begin
        cur = st_r[s-1];
      end
      for (int j = 0; j < 2; j++) begin
        k  = QUO_W - 1 - 2 * s - j;
        sh = (NUM_W + 1)'(cur.d) << k;
        if (k >= 0) begin
          if ({1'b0, cur.rem} >= sh) begin
            cur.rem = cur.rem - sh[NUM_W-1:0];
            cur.q   = {cur.q[QUO_W-2:0], 1'b1};
          end else begin
            cur.q   = {cur.q[QUO_W-2:0], 1'b0};
          end
        end
      end
      st_nxt[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].q;

endmodule

>>> src/psc_stick.sv
// ----------------------------------------------------------------------------
// psc_stick
// one stick: dead zone, gate products, square root and scaling divide
// ----------------------------------------------------------------------------
module psc_stick
  import psc_pkg::*;
#(
  parameter int RADIUS = MAIN_RADIUS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     circ,
  input  stk_cfg_t                 cfg,
  input  logic signed [AXIS_W-1:0] in_x,
  input  logic signed [AXIS_W-1:0] in_y,
  output logic signed [AXIS_W-1:0] res_x,
  output logic signed [AXIS_W-1:0] res_y
);

  localparam logic [RAD_W-1:0]   RAD    = RAD_W'(RADIUS);
  localparam logic [2*RAD_W-1:0] RAD_SQ = (2*RAD_W)'(RADIUS * RADIUS);

  // stage 1: magnitudes after dead zone
  logic [7:0] absx, absy, magx, magy;
  logic       circ1_r, negx1_r, negy1_r;
  logic [7:0] ax1_r, ay1_r;

  always_comb begin
    absx = in_x[7] ? (~in_x + 8'd1) : in_x;
    absy = in_y[7] ? (~in_y + 8'd1) : in_y;
    magx = (absx <= {1'b0, cfg.dead}) ? 8'd0 : absx - {1'b0, cfg.dead};
    magy = (absy <= {1'b0, cfg.dead}) ? 8'd0 : absy - {1'b0, cfg.dead};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      circ1_r <= circ;
      negx1_r <= in_x[7];
      negy1_r <= in_y[7];
      ax1_r   <= magx;
      ay1_r   <= magy;
    end
  end

  // stage 2: gate weights and squares
  logic signed [7:0]  w;
  logic        [14:0] xyx2_r, xyy2_r;
  logic signed [16:0] wax2_r, way2_r;
  logic        [13:0] p2_r;
  logic        [14:0] cx2_r, cy2_r, rx2_r, ry2_r;
  logic               circ2_r, negx2_r, negy2_r;
  logic        [7:0]  ax2_r, ay2_r;

  assign w = $signed({1'b0, cfg.max}) - $signed({1'b0, cfg.xy});

  always_ff @(posedge clk) begin
    if (en) begin
      xyx2_r  <= cfg.xy * ax1_r;
      xyy2_r  <= cfg.xy * ay1_r;
      wax2_r  <= w * $signed({1'b0, ax1_r});
      way2_r  <= w * $signed({1'b0, ay1_r});
      p2_r    <= cfg.xy * cfg.max;
      cx2_r   <= ax1_r * ax1_r;
      cy2_r   <= ay1_r * ay1_r;
      rx2_r   <= ax1_r * RAD;
      ry2_r   <= ay1_r * RAD;
      circ2_r <= circ1_r;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
      ax2_r   <= ax1_r;
      ay2_r   <= ay1_r;
    end
  end

  // stage 3: weighted length, scale decision, numerators
  typedef struct packed {
    logic             circ;
    logic             scale;
    logic [NUM_W-1:0] nx;
    logic [NUM_W-1:0] ny;
    logic [DEN_W-1:0] dv;
    logic             negx;
    logic             negy;
    logic [7:0]       ax;
    logic [7:0]       ay;
  } s3_t;

  logic signed [16:0] dlen;
  logic               oscale, cscale;
  logic [21:0]        px, py;
  logic [15:0]        sq;
  s3_t                s3_nxt, s3_r;
  logic [15:0]        sq3_r;

  always_comb begin
    if (xyy2_r <= xyx2_r) begin
      dlen = $signed({2'b00, xyx2_r}) + way2_r;
    end else begin
      dlen = $signed({2'b00, xyy2_r}) + wax2_r;
    end
    oscale       = $signed({3'b000, p2_r}) < dlen;
    px           = p2_r * ax2_r;
    py           = p2_r * ay2_r;
    sq           = {1'b0, cx2_r} + {1'b0, cy2_r};
    cscale       = {2'b00, RAD_SQ} < sq;
    s3_nxt.circ  = circ2_r;
    s3_nxt.scale = circ2_r ? cscale : oscale;
    s3_nxt.nx    = circ2_r ? NUM_W'(rx2_r) : px[NUM_W-1:0];
    s3_nxt.ny    = circ2_r ? NUM_W'(ry2_r) : py[NUM_W-1:0];
    s3_nxt.dv    = dlen[DEN_W-1:0];
    s3_nxt.negx  = negx2_r;
    s3_nxt.negy  = negy2_r;
    s3_nxt.ax    = ax2_r;
    s3_nxt.ay    = ay2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r  <= s3_nxt;
      sq3_r <= sq;
    end
  end

  // square root of the squared length
  logic [7:0] root;

  psc_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .val  (sq3_r),
    .root (root)
  );

  // hold the rest alongside the root and the divide
  s3_t dla_r [SQRT_STAGES];
  s3_t dlb_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      dla_r[0] <= s3_r;
      for (int i = 1; i < SQRT_STAGES; i++) begin
        dla_r[i] <= dla_r[i-1];
      end
      dlb_r[0] <= dla_r[SQRT_STAGES-1];
      for (int i = 1; i < DIV_STAGES; i++) begin
        dlb_r[i] <= dlb_r[i-1];
      end
    end
  end

  // scaling divides
  s3_t              sa;
  logic [DEN_W-1:0] den;
  logic [QUO_W-1:0] qx, qy;

  assign sa  = dla_r[SQRT_STAGES-1];
  assign den = sa.circ ? DEN_W'(root) : sa.dv;

  psc_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (sa.nx),
    .den (den),
    .quo (qx)
  );

  psc_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (sa.ny),
    .den (den),
    .quo (qy)
  );

  // pick scaled or plain magnitude, restore sign
  s3_t        sb;
  logic [7:0] fx, fy;

  always_comb begin
    sb    = dlb_r[DIV_STAGES-1];
    fx    = sb.scale ? {1'b0, qx} : sb.ax;
    fy    = sb.scale ? {1'b0, qy} : sb.ay;
    res_x = sb.negx ? $signed(~fx + 8'd1) : $signed(fx);
    res_y = sb.negy ? $signed(~fy + 8'd1) : $signed(fy);
  end

endmodule

>>> src/pad_stick_trigger_clamp.sv
// ----------------------------------------------------------------------------
// pad_stick_trigger_clamp
// game pad sample conditioning: stick dead zone and gate, trigger clamp
// ----------------------------------------------------------------------------
// Takes one pad word per clock and returns it conditioned; with
// out_ready held high a new word enters every cycle. The stick path sets
// the depth: registered dead zone and gate arithmetic stages, a
// four-stage square root and a four-stage divider, then the output register.
// A low out_ready holds the whole pipeline while out_valid is high, so in_ready follows it.
module pad_stick_trigger_clamp
  import psc_pkg::*;
#(
  parameter int MAIN_RADIUS = MAIN_RADIUS_DEF,
  parameter int SUB_RADIUS  = SUB_RADIUS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input words
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic                     in_pad_error,
  input  logic signed [AXIS_W-1:0] in_stick_x,
  input  logic signed [AXIS_W-1:0] in_stick_y,
  input  logic signed [AXIS_W-1:0] in_sub_x,
  input  logic signed [AXIS_W-1:0] in_sub_y,
  input  logic        [TRIG_W-1:0] in_trig_l,
  input  logic        [TRIG_W-1:0] in_trig_r,
  // result words
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [AXIS_W-1:0] out_stick_x,
  output logic signed [AXIS_W-1:0] out_stick_y,
  output logic signed [AXIS_W-1:0] out_sub_x,
  output logic signed [AXIS_W-1:0] out_sub_y,
  output logic        [TRIG_W-1:0] out_trig_l,
  output logic        [TRIG_W-1:0] out_trig_r,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // configuration registers
  logic [TRIG_W-1:0] trig_min_r, trig_max_r;
  logic [LIM_W-1:0]  main_dead_r, main_max_r, main_xy_r;
  logic [LIM_W-1:0]  sub_dead_r, sub_max_r, sub_xy_r;
  reg_idx_t          widx;

  assign widx   = reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_min_r  <= TRIG_MIN_RST;
      trig_max_r  <= TRIG_MAX_RST;
      main_dead_r <= MAIN_DEAD_RST;
      main_max_r  <= MAIN_MAX_RST;
      main_xy_r   <= MAIN_XY_RST;
      sub_dead_r  <= SUB_DEAD_RST;
      sub_max_r   <= SUB_MAX_RST;
      sub_xy_r    <= SUB_XY_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_TRIG_MIN:  trig_min_r  <= pwdata[TRIG_W-1:0];
        REG_TRIG_MAX:  trig_max_r  <= pwdata[TRIG_W-1:0];
        REG_MAIN_DEAD: main_dead_r <= pwdata[LIM_W-1:0];
        REG_MAIN_MAX:  main_max_r  <= pwdata[LIM_W-1:0];
        REG_MAIN_XY:   main_xy_r   <= pwdata[LIM_W-1:0];
        REG_SUB_DEAD:  sub_dead_r  <= pwdata[LIM_W-1:0];
        REG_SUB_MAX:   sub_max_r   <= pwdata[LIM_W-1:0];
        REG_SUB_XY:    sub_xy_r    <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (widx)
      REG_TRIG_MIN:  prdata = 32'(trig_min_r);
      REG_TRIG_MAX:  prdata = 32'(trig_max_r);
      REG_MAIN_DEAD: prdata = 32'(main_dead_r);
      REG_MAIN_MAX:  prdata = 32'(main_max_r);
      REG_MAIN_XY:   prdata = 32'(main_xy_r);
      REG_SUB_DEAD:  prdata = 32'(sub_dead_r);
      REG_SUB_MAX:   prdata = 32'(sub_max_r);
      REG_SUB_XY:    prdata = 32'(sub_xy_r);
      default:       prdata = '0;
    endcase
  end

  // pipeline advance
  logic               en;
  logic [STICK_LAT-1:0] v_r;
  logic               out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[STICK_LAT-2:0], in_valid};
      out_valid_r <= v_r[STICK_LAT-1];
    end
  end

  // trigger clamp
  logic [TRIG_W-1:0] tl_c, tr_c;

  always_comb begin
    if (in_trig_l <= trig_min_r) begin
      tl_c = '0;
    end else begin
      tl_c = ((in_trig_l > trig_max_r) ? trig_max_r : in_trig_l) - trig_min_r;
    end
    if (in_trig_r <= trig_min_r) begin
      tr_c = '0;
    end else begin
      tr_c = ((in_trig_r > trig_max_r) ? trig_max_r : in_trig_r) - trig_min_r;
    end
  end

  // side data carried next to the stick pipelines
  typedef struct packed {
    logic              err;
    logic              circ;
    logic [AXIS_W-1:0] mx;
    logic [AXIS_W-1:0] my;
    logic [AXIS_W-1:0] sx;
    logic [AXIS_W-1:0] sy;
    logic [TRIG_W-1:0] tl;
    logic [TRIG_W-1:0] tr;
    logic [TRIG_W-1:0] tl_raw;
    logic [TRIG_W-1:0] tr_raw;
  } side_t;

  side_t side_r [STICK_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{err: in_pad_error, circ: in_cmd, mx: in_stick_x, my: in_stick_y,
                     sx: in_sub_x, sy: in_sub_y, tl: tl_c, tr: tr_c,
                     tl_raw: in_trig_l, tr_raw: in_trig_r};
      for (int i = 1; i < STICK_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // stick pipelines
  stk_cfg_t          main_cfg, sub_cfg;
  logic signed [7:0] mres_x, mres_y, sres_x, sres_y;

  assign main_cfg = '{dead: main_dead_r, max: main_max_r, xy: main_xy_r};
  assign sub_cfg  = '{dead: sub_dead_r, max: sub_max_r, xy: sub_xy_r};

  psc_stick #(.RADIUS(MAIN_RADIUS)) u_main (
    .clk   (clk),
    .en    (en),
    .circ  (in_cmd),
    .cfg   (main_cfg),
    .in_x  (in_stick_x),
    .in_y  (in_stick_y),
    .res_x (mres_x),
    .res_y (mres_y)
  );

  psc_stick #(.RADIUS(SUB_RADIUS)) u_sub (
    .clk   (clk),
    .en    (en),
    .circ  (in_cmd),
    .cfg   (sub_cfg),
    .in_x  (in_sub_x),
    .in_y  (in_sub_y),
    .res_x (sres_x),
    .res_y (sres_y)
  );

  // output register, error words pass unchanged
  side_t last;
  logic  out_err_r, out_circ_r;

  assign last = side_r[STICK_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_err_r   <= last.err;
      out_circ_r  <= last.circ;
      out_stick_x <= last.err ? $signed(last.mx) : mres_x;
      out_stick_y <= last.err ? $signed(last.my) : mres_y;
      out_sub_x   <= last.err ? $signed(last.sx) : sres_x;
      out_sub_y   <= last.err ? $signed(last.sy) : sres_y;
      out_trig_l  <= last.err ? last.tl_raw : last.tl;
      out_trig_r  <= last.err ? last.tr_raw : last.tr;
    end
  end

`ifndef SYNTHESIS
  // a stall freezes every valid bit in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid chain moved during stall");

  // clamped trigger stays within the configured span
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_err_r && (trig_max_r >= trig_min_r) |->
      (out_trig_l <= trig_max_r - trig_min_r) && (out_trig_r <= trig_max_r - trig_min_r))
    else $error("trigger above span");

  // circle gate keeps each main axis inside the radius
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_err_r && out_circ_r |->
      (int'(out_stick_x) <= MAIN_RADIUS) && (int'(out_stick_x) >= -MAIN_RADIUS) &&
      (int'(out_stick_y) <= MAIN_RADIUS) && (int'(out_stick_y) >= -MAIN_RADIUS))
    else $error("main stick outside circle");
`endif

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// pad stick and trigger clamp: streams pad words through the block under
// several register settings and checks every result word against a local
// predictor of the dead zone, gate and trigger logic
// ----------------------------------------------------------------------------
module testbench;
  import psc_pkg::*;

  localparam int MAIN_RAD   = 56;
  localparam int SUB_RAD    = 44;
  localparam int STALL_LIM  = 4000;
  localparam int DRAIN_WAIT = STICK_LAT + 8;

  typedef struct {
    logic                     cmd;
    logic                     pad_error;
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
    logic signed [AXIS_W-1:0] sub_x;
    logic signed [AXIS_W-1:0] sub_y;
    logic        [TRIG_W-1:0] trig_l;
    logic        [TRIG_W-1:0] trig_r;
  } pad_word_t;

  typedef struct {
    logic [AXIS_W-1:0] stick_x;
    logic [AXIS_W-1:0] stick_y;
    logic [AXIS_W-1:0] sub_x;
    logic [AXIS_W-1:0] sub_y;
    logic [TRIG_W-1:0] trig_l;
    logic [TRIG_W-1:0] trig_r;
  } pad_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_cmd;
  logic                     in_pad_error;
  logic signed [AXIS_W-1:0] in_stick_x;
  logic signed [AXIS_W-1:0] in_stick_y;
  logic signed [AXIS_W-1:0] in_sub_x;
  logic signed [AXIS_W-1:0] in_sub_y;
  logic        [TRIG_W-1:0] in_trig_l;
  logic        [TRIG_W-1:0] in_trig_r;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [AXIS_W-1:0] out_stick_x;
  logic signed [AXIS_W-1:0] out_stick_y;
  logic signed [AXIS_W-1:0] out_sub_x;
  logic signed [AXIS_W-1:0] out_sub_y;
  logic        [TRIG_W-1:0] out_trig_l;
  logic        [TRIG_W-1:0] out_trig_r;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [4:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  pad_word_t   word_q[$];
  pad_result_t clamp_q[$];
  int          reg_val[8];
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold;
  int          errors;
  int          stall_cnt;
  bit          in_fire;

  pad_stick_trigger_clamp dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // integer square root, truncated
  function automatic int isqrt_floor(input int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // octagonal gate with per-axis dead zone
  function automatic void gate_octagon(input int ix, input int iy, input int lim,
                                       input int xy, input int dz,
                                       output int ox, output int oy);
    int x, y, sx, sy, d;
    x = ix;
    y = iy;
    sx = 1;
    sy = 1;
    if (x < 0) begin
      sx = -1;
      x = -x;
    end
    if (y < 0) begin
      sy = -1;
      y = -y;
    end
    x = (x <= dz) ? 0 : x - dz;
    y = (y <= dz) ? 0 : y - dz;
    if (x == 0 && y == 0) begin
      ox = 0;
      oy = 0;
      return;
    end
    if (xy * y <= xy * x) d = xy * x + (lim - xy) * y;
    else d = xy * y + (lim - xy) * x;
    if (xy * lim < d) begin
      x = (xy * lim * x) / d;
      y = (xy * lim * y) / d;
    end
    ox = sx * x;
    oy = sy * y;
  endfunction

  function automatic int circle_dz(input int v, input int dz);
    if (-dz < v && v < dz) return 0;
    if (v > 0) return v - dz;
    return v + dz;
  endfunction

  // circular gate of fixed radius
  function automatic void gate_circle(input int ix, input int iy, input int rad,
                                      input int dz, output int ox, output int oy);
    int x, y, sq, len;
    x = circle_dz(ix, dz);
    y = circle_dz(iy, dz);
    sq = x * x + y * y;
    if (rad * rad < sq) begin
      len = isqrt_floor(sq);
      if (len > 0) begin
        x = (x * rad) / len;
        y = (y * rad) / len;
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic logic [TRIG_W-1:0] trig_level(input int t);
    int v;
    v = t;
    if (v <= reg_val[REG_TRIG_MIN]) return '0;
    if (v > reg_val[REG_TRIG_MAX]) v = reg_val[REG_TRIG_MAX];
    return TRIG_W'(v - reg_val[REG_TRIG_MIN]);
  endfunction

  function automatic pad_result_t clamp_word(input pad_word_t w);
    pad_result_t r;
    int mx, my, sx, sy;
    mx = w.stick_x;
    my = w.stick_y;
    sx = w.sub_x;
    sy = w.sub_y;
    r.trig_l = w.trig_l;
    r.trig_r = w.trig_r;
    if (!w.pad_error) begin
      if (w.cmd) begin
        gate_circle(mx, my, MAIN_RAD, reg_val[REG_MAIN_DEAD], mx, my);
        gate_circle(sx, sy, SUB_RAD, reg_val[REG_SUB_DEAD], sx, sy);
      end else begin
        gate_octagon(mx, my, reg_val[REG_MAIN_MAX], reg_val[REG_MAIN_XY],
                     reg_val[REG_MAIN_DEAD], mx, my);
        gate_octagon(sx, sy, reg_val[REG_SUB_MAX], reg_val[REG_SUB_XY],
                     reg_val[REG_SUB_DEAD], sx, sy);
      end
      r.trig_l = trig_level(w.trig_l);
      r.trig_r = trig_level(w.trig_r);
    end
    r.stick_x = AXIS_W'(mx);
    r.stick_y = AXIS_W'(my);
    r.sub_x   = AXIS_W'(sx);
    r.sub_y   = AXIS_W'(sy);
    return r;
  endfunction

  // input side: predict each accepted word
  always @(posedge clk) begin
    in_fire = in_valid && in_ready;
    if (in_fire) begin
      clamp_q.insert(clamp_q.size(),
                     clamp_word('{in_cmd, in_pad_error, in_stick_x, in_stick_y,
                                  in_sub_x, in_sub_y, in_trig_l, in_trig_r}));
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (word_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        pad_word_t w;
        w = word_q.pop_front();
        in_cmd       <= w.cmd;
        in_pad_error <= w.pad_error;
        in_stick_x   <= w.stick_x;
        in_stick_y   <= w.stick_y;
        in_sub_x     <= w.sub_x;
        in_sub_y     <= w.sub_y;
        in_trig_l    <= w.trig_l;
        in_trig_r    <= w.trig_r;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and long hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (clamp_q.size() == 0) begin
        $display("%0t: unexpected word %h %h %h %h %h %h", $time, out_stick_x,
                 out_stick_y, out_sub_x, out_sub_y, out_trig_l, out_trig_r);
        errors++;
      end else begin
        pad_result_t e;
        e = clamp_q.pop_front();
        if (out_stick_x !== e.stick_x) begin
          $display("%0t: stick_x exp %h got %h", $time, e.stick_x, out_stick_x);
          errors++;
        end
        if (out_stick_y !== e.stick_y) begin
          $display("%0t: stick_y exp %h got %h", $time, e.stick_y, out_stick_y);
          errors++;
        end
        if (out_sub_x !== e.sub_x) begin
          $display("%0t: sub_x exp %h got %h", $time, e.sub_x, out_sub_x);
          errors++;
        end
        if (out_sub_y !== e.sub_y) begin
          $display("%0t: sub_y exp %h got %h", $time, e.sub_y, out_sub_y);
          errors++;
        end
        if (out_trig_l !== e.trig_l) begin
          $display("%0t: trig_l exp %h got %h", $time, e.trig_l, out_trig_l);
          errors++;
        end
        if (out_trig_r !== e.trig_r) begin
          $display("%0t: trig_r exp %h got %h", $time, e.trig_r, out_trig_r);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (word_q.size() == 0 && clamp_q.size() == 0)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= STALL_LIM) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input reg_idx_t idx, input int val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = 5'(idx * 4);
    pwdata  = 32'(val);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_val[idx] = (idx <= REG_TRIG_MAX) ? (val & 8'hff) : (val & 7'h7f);
  endtask

  task automatic load_regs(input int tmin, input int tmax, input int md, input int mm,
                           input int mxy, input int sd, input int sm, input int sxy);
    reg_write(REG_TRIG_MIN, tmin);
    reg_write(REG_TRIG_MAX, tmax);
    reg_write(REG_MAIN_DEAD, md);
    reg_write(REG_MAIN_MAX, mm);
    reg_write(REG_MAIN_XY, mxy);
    reg_write(REG_SUB_DEAD, sd);
    reg_write(REG_SUB_MAX, sm);
    reg_write(REG_SUB_XY, sxy);
  endtask

  task automatic push_word(input logic cmd, input logic perr, input int mx, input int my,
                           input int sx, input int sy, input int tl, input int tr);
    pad_word_t w;
    w = '{cmd, perr, AXIS_W'(mx), AXIS_W'(my), AXIS_W'(sx), AXIS_W'(sy),
          TRIG_W'(tl), TRIG_W'(tr)};
    word_q.insert(word_q.size(), w);
  endtask

  // axis value, often near the dead zone edges
  function automatic int pick_axis();
    int k;
    k = $urandom_range(3);
    if (k == 0) return $signed(8'($urandom_range(255)));
    if (k == 1) return int'($urandom_range(40)) - 20;
    if (k == 2) return $urandom_range(1) ? 127 - int'($urandom_range(10))
                                         : -128 + int'($urandom_range(10));
    return int'($urandom_range(160)) - 80;
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      push_word(1'($urandom_range(1)), $urandom_range(9) == 0, pick_axis(), pick_axis(),
                pick_axis(), pick_axis(), $urandom_range(255), $urandom_range(255));
    end
  endtask

  task automatic drain();
    wait (word_q.size() == 0 && !in_valid && clamp_q.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = 1'b0;
    in_pad_error = 1'b0;
    in_stick_x = '0;
    in_stick_y = '0;
    in_sub_x = '0;
    in_sub_y = '0;
    in_trig_l = '0;
    in_trig_r = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_fire = 1'b0;
    errors = 0;
    stall_cnt = 0;
    rx_hold = 0;
    tx_idle_pct = 37;
    rx_idle_pct = 37;
    reg_val = '{30, 180, 15, 72, 40, 15, 59, 31};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words under reset settings
    push_word(0, 0, 0, 0, 0, 0, 0, 0);
    push_word(0, 0, 127, 127, 127, 127, 255, 255);
    push_word(0, 0, -128, -128, -128, -128, 30, 31);
    push_word(1, 0, 127, -128, -128, 127, 180, 181);
    push_word(1, 0, -128, -128, 127, 127, 29, 100);
    push_word(0, 1, -128, 127, 5, -5, 255, 0);
    push_word(1, 1, 127, -128, -7, 3, 0, 255);
    push_word(0, 0, 15, -15, 16, -16, 1, 179);
    push_word(1, 0, 15, -15, 14, -14, 31, 254);
    push_word(1, 0, 16, -16, 60, 0, 128, 127);
    push_word(0, 0, 80, 0, 0, -80, 64, 200);
    push_word(0, 0, 60, 60, -60, 60, 10, 90);
    push_word(1, 0, 100, 0, 0, 100, 170, 50);
    drain();

    // all registers written at their extremes of zero
    load_regs(0, 0, 0, 0, 0, 0, 0, 0);
    push_word(0, 0, -128, 0, 0, -128, 0, 1);
    push_word(1, 0, -128, -128, -128, 0, 255, 0);
    push_word(0, 0, 1, 1, -1, -1, 128, 2);
    push_word(1, 0, 0, 0, 0, 0, 0, 0);
    push_random(100);
    drain();

    // full scale limits, receiver holds off long so the pipe backs up
    load_regs(255, 255, 127, 127, 127, 127, 127, 127);
    tx_idle_pct = 0;
    rx_hold = 300;
    push_random(110);
    drain();
    tx_idle_pct = 37;

    // inverted trigger limits, diagonal above axis limit
    load_regs(200, 50, 5, 30, 100, 3, 20, 90);
    push_word(0, 0, 127, 127, -128, -128, 255, 201);
    push_word(0, 0, 100, -100, 50, 60, 200, 199);
    push_random(110);
    drain();

    // stretch with no idling on either side
    load_regs(30, 180, 15, 72, 40, 15, 59, 31);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random(110);
    drain();
    tx_idle_pct = 37;
    rx_idle_pct = 37;

    // random settings
    for (int p = 0; p < 3; p++) begin
      load_regs($urandom_range(255), $urandom_range(255), $urandom_range(40),
                $urandom_range(127), $urandom_range(127), $urandom_range(40),
                $urandom_range(127), $urandom_range(127));
      push_random(75);
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> pad_stick_trigger_clamp.f
src/psc_pkg.sv
src/psc_isqrt.sv
src/psc_div.sv
src/psc_stick.sv
src/pad_stick_trigger_clamp.sv
test/testbench.sv
